>>> src/rfo_pkg.sv
// Shared types and constants for the ring FIFO with overwrite.
`timescale 1ns / 1ps
`default_nettype none
package rfo_pkg;

  // Build-time defaults
  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int EXT_W    = 64;
  localparam int CNT_EXT_W = 16;

  // Access codes
  typedef enum logic [1:0] {
    CMD_PEEK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell control: shift towards the head, or load the write item
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> src/rfo_cell.sv
// One storage cell of the FIFO chain: holds an item, takes its neighbour's on a shift.
`timescale 1ns / 1ps
`default_nettype none
module rfo_cell #(
  parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire rfo_pkg::cell_ctl_t    ctl,
  input  wire logic [ITEM_WIDTH-1:0] nbr,
  input  wire logic [ITEM_WIDTH-1:0] wdata,
  output logic      [ITEM_WIDTH-1:0] q
);

  // Load wins over shift; the loaded slot is never the one shifted out of
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= wdata;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule
`default_nettype wire

>>> src/rfo_chain.sv
// Row of storage cells; cell 0 holds the oldest item, items move one cell per shift.
`timescale 1ns / 1ps
`default_nettype none
module rfo_chain #(
  parameter int DEPTH      = rfo_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic                  load,
  input  wire logic [IDX_W-1:0]      load_pos,
  input  wire logic [ITEM_WIDTH-1:0] wdata,
  output logic      [ITEM_WIDTH-1:0] head
);

  logic [ITEM_WIDTH-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rfo_pkg::cell_ctl_t    ctl;
    logic [ITEM_WIDTH-1:0] nbr;

    // Each cell decodes its own place for the write
    assign ctl.shift = shift;
    assign ctl.load  = load && (load_pos == IDX_W'(i));

    // Tail cell has no neighbour; it keeps its own value on a shift
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = q[i];
    end else begin : g_mid
      assign nbr = q[i+1];
    end

    rfo_cell #(
      .ITEM_WIDTH(ITEM_WIDTH)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .nbr  (nbr),
      .wdata(wdata),
      .q    (q[i])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

>>> src/ring_fifo_with_overwrite.sv
// Top level of the ring FIFO with overwrite: access decode, fill count and result register.
`timescale 1ns / 1ps
`default_nettype none
// One access (peek, read or write) is taken per transfer on the input side and
// gives one result, registered, in the cycle after. Items sit in a chain of
// DEPTH cells with the oldest in the first cell, so a read or an overwriting
// write shifts the whole chain by one place in the same cycle; a new access
// is taken whenever the result register is empty or is drained in that cycle.
// A write to a full queue is refused (status full) unless its overwrite flag
// drops the oldest item. Every result carries the fill count after the access;
// read data is zero unless a peek or read found an item. No clearing pass
// follows reset.
module ring_fifo_with_overwrite #(
  parameter int DEPTH      = rfo_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = rfo_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    command,
  input  wire logic [rfo_pkg::DATA_W-1:0]    write_data,
  input  wire logic                          overwrite,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [rfo_pkg::DATA_W-1:0]         read_data,
  output logic [rfo_pkg::COUNT_W-1:0]        item_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                   take;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   empty;
  logic                   full;
  logic                   shift;
  logic                   load;
  logic [IDX_W-1:0]       load_pos;
  logic [ITEM_WIDTH-1:0]  head;
  logic [ITEM_WIDTH-1:0]  store_data;
  logic [rfo_pkg::EXT_W-1:0]     wd_ext;
  logic [rfo_pkg::EXT_W-1:0]     head_ext;
  logic [rfo_pkg::CNT_EXT_W-1:0] cnt_ext;
  logic [1:0]                    status_next;
  logic [rfo_pkg::DATA_W-1:0]    rdata_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));

  // Fit the port data to the item width and back
  assign wd_ext     = rfo_pkg::EXT_W'(write_data);
  assign store_data = wd_ext[ITEM_WIDTH-1:0];
  assign head_ext   = rfo_pkg::EXT_W'(head);

  // Access decode
  always_comb begin
    shift       = 1'b0;
    load        = 1'b0;
    load_pos    = count[IDX_W-1:0];
    count_next  = count;
    status_next = rfo_pkg::ST_OK;
    rdata_next  = '0;
    case (command)
      rfo_pkg::CMD_PEEK: begin
        if (empty) begin
          status_next = rfo_pkg::ST_EMPTY;
        end else begin
          rdata_next = head_ext[rfo_pkg::DATA_W-1:0];
        end
      end
      rfo_pkg::CMD_READ: begin
        if (empty) begin
          status_next = rfo_pkg::ST_EMPTY;
        end else begin
          rdata_next = head_ext[rfo_pkg::DATA_W-1:0];
          shift      = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      rfo_pkg::CMD_WRITE: begin
        if (full) begin
          if (overwrite) begin
            // drop the oldest, new item lands in the last cell
            shift    = 1'b1;
            load     = 1'b1;
            load_pos = IDX_W'(DEPTH - 1);
          end else begin
            status_next = rfo_pkg::ST_FULL;
          end
        end else begin
          load       = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  rfo_chain #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_chain (
    .clk     (clk),
    .shift   (shift && take),
    .load    (load && take),
    .load_pos(load_pos),
    .wdata   (store_data),
    .head    (head)
  );

  // Fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count <= count_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cnt_ext = rfo_pkg::CNT_EXT_W'(count_next);

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      status     <= status_next;
      read_data  <= rdata_next;
      item_count <= cnt_ext[rfo_pkg::COUNT_W-1:0];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("transfer gave no result");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (take && full && !overwrite && command == rfo_pkg::CMD_WRITE) |=>
      (status == rfo_pkg::ST_FULL && count == $past(count)))
    else $error("refused write changed the queue");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (take && empty && (command == rfo_pkg::CMD_READ || command == rfo_pkg::CMD_PEEK)) |=>
      (status == rfo_pkg::ST_EMPTY && read_data == '0 && count == '0))
    else $error("access on empty queue misreported");

endmodule
`default_nettype wire
